[hdl/clnw_pkg.sv]
// shared types and constants for the character lcd nibble writer
`default_nettype none

package clnw_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 7;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FUNCTION_BITS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISPLAY_BITS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_LINE   = 2'd2;

    // request types
    localparam logic [1:0] REQ_CHAR = 2'd0;
    localparam logic [1:0] REQ_POS  = 2'd1;
    localparam logic [1:0] REQ_FLAG = 2'd2;
    localparam logic [1:0] REQ_INIT = 2'd3;

    // flag selects
    localparam logic [1:0] FLAG_DISPLAY = 2'd0;
    localparam logic [1:0] FLAG_CURSOR  = 2'd1;
    localparam logic [1:0] FLAG_BLINK   = 2'd2;
    // no flag behind it, the request is ignored
    localparam logic [1:0] FLAG_UNNAMED = 2'd3;

    // special characters
    localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [7:0] CHAR_FORM_FEED = 8'd12;
    localparam logic [7:0] CHAR_RETURN    = 8'd13;

    // lcd commands
    localparam logic [7:0] LCD_CLEAR      = 8'h01;
    localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] LCD_DISPLAY    = 8'h08;
    localparam logic [7:0] LCD_FUNCTION   = 8'h20;
    localparam logic [7:0] LCD_SET_ADDR   = 8'h80;

    localparam logic [3:0] NIB_INIT_THREE = 4'h3;
    localparam logic [3:0] NIB_INIT_TWO   = 4'h2;

    // hold codes
    localparam logic [2:0] WAIT_NONE  = 3'd0;
    localparam logic [2:0] WAIT_PULSE = 3'd1;
    localparam logic [2:0] WAIT_3MS   = 3'd2;
    localparam logic [2:0] WAIT_5MS   = 3'd3;
    localparam logic [2:0] WAIT_8MS   = 3'd4;
    localparam logic [2:0] WAIT_15MS  = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BYTE,
        ST_ZERO,
        ST_NIB,
        ST_IBYTE
    } state_t;

    typedef enum logic [1:0] {
        CLS_SKIP,
        CLS_BYTE,
        CLS_INIT
    } cls_t;

    typedef enum logic [1:0] {
        RS_HOLD,
        RS_ZERO,
        RS_BYTE
    } rs_sel_t;

    typedef enum logic [2:0] {
        NIB_HOLD,
        NIB_ZERO,
        NIB_HI,
        NIB_LO,
        NIB_THREE,
        NIB_TWO
    } nib_sel_t;

    typedef enum logic [2:0] {
        BSEL_REQ,
        BSEL_FUNC,
        BSEL_DISP,
        BSEL_CLEAR,
        BSEL_ENTRY
    } byte_sel_t;

    typedef struct packed {
        logic      load_req;
        logic      emit;
        rs_sel_t   rs_sel;
        nib_sel_t  nib_sel;
        byte_sel_t byte_sel;
        logic      en;
        logic [2:0] wait_code;
        logic      end_wait;
        logic      last;
    } cmd_t;

    typedef struct packed {
        cls_t cls;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

[hdl/clnw_ctrl.sv]
// sequencer that steps through the pin states of each request
`default_nettype none

module clnw_ctrl
    import clnw_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t     state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic [1:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= 3'd0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        in_ready      = 1'b0;
        cmd.load_req  = 1'b0;
        cmd.emit      = 1'b0;
        cmd.rs_sel    = RS_HOLD;
        cmd.nib_sel   = NIB_HOLD;
        cmd.byte_sel  = BSEL_REQ;
        cmd.en        = 1'b0;
        cmd.wait_code = WAIT_NONE;
        cmd.end_wait  = 1'b0;
        cmd.last      = 1'b0;

        if (state_reg == ST_IBYTE)
        begin
            unique case (idx_reg)
                2'd0:    cmd.byte_sel = BSEL_FUNC;
                2'd1:    cmd.byte_sel = BSEL_DISP;
                2'd2:    cmd.byte_sel = BSEL_CLEAR;
                default: cmd.byte_sel = BSEL_ENTRY;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    phase_next   = 3'd0;
                    idx_next     = 2'd0;
                    unique case (stat.cls)
                        CLS_BYTE: state_next = ST_BYTE;
                        CLS_INIT: state_next = ST_ZERO;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end

            ST_BYTE, ST_IBYTE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    phase_next = phase_reg + 3'd1;
                    unique case (phase_reg)
                        3'd0: cmd.rs_sel  = RS_BYTE;
                        3'd2: cmd.nib_sel = NIB_HI;
                        3'd5: cmd.nib_sel = NIB_LO;
                        3'd3, 3'd6:
                        begin
                            cmd.en        = 1'b1;
                            cmd.wait_code = WAIT_PULSE;
                        end
                        3'd7:
                        begin
                            cmd.end_wait = 1'b1;
                            if (state_reg == ST_BYTE || idx_reg == 2'd3)
                            begin
                                cmd.last   = 1'b1;
                                state_next = ST_IDLE;
                            end
                            else
                            begin
                                idx_next = idx_reg + 2'd1;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_ZERO:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.rs_sel    = RS_ZERO;
                    cmd.nib_sel   = NIB_ZERO;
                    cmd.wait_code = WAIT_15MS;
                    state_next    = ST_NIB;
                    phase_next    = 3'd0;
                    idx_next      = 2'd0;
                end
            end

            ST_NIB:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    phase_next = phase_reg + 3'd1;
                    unique case (phase_reg)
                        3'd0:
                            cmd.nib_sel = (idx_reg == 2'd3) ? NIB_TWO : NIB_THREE;
                        3'd1:
                        begin
                            cmd.en        = 1'b1;
                            cmd.wait_code = WAIT_PULSE;
                        end
                        default:
                        begin
                            phase_next = 3'd0;
                            if (idx_reg == 2'd3)
                            begin
                                state_next = ST_IBYTE;
                                idx_next   = 2'd0;
                            end
                            else
                            begin
                                cmd.wait_code = WAIT_5MS;
                                idx_next      = idx_reg + 2'd1;
                            end
                        end
                    endcase
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

[hdl/clnw_datapath.sv]
// request decode, held pin state, configuration and result register
`default_nettype none

module clnw_datapath
    import clnw_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [1:0]             req_type,
    input  wire logic [7:0]             char_code,
    input  wire logic [6:0]             column,
    input  wire logic                   line_sel,
    input  wire logic [1:0]             flag_select,
    input  wire logic                   flag_value,
    input  wire cmd_t                   cmd,
    output stat_t                       stat,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        pin_rs,
    output logic                        pin_en,
    output logic [3:0]                  pin_nibble,
    output logic [2:0]                  wait_code,
    output logic                        last_of_run
);

    logic [4:0] function_bits_reg;
    logic [2:0] display_bits_reg;
    logic [6:0] second_line_reg;
    logic [7:0] display_mode_reg, display_mode_next;
    logic       held_rs_reg;
    logic [3:0] held_nibble_reg;
    logic [7:0] byte_reg, byte_next;
    logic       byte_rs_reg, byte_rs_next;
    logic [2:0] byte_wait_reg, byte_wait_next;
    logic       out_valid_reg;
    logic       rs_reg, en_reg, last_reg;
    logic [3:0] nibble_reg;
    logic [2:0] wait_reg;

    logic [7:0] flag_bit;
    logic [6:0] line_base;
    logic [6:0] pos_addr;
    logic [7:0] sel_byte;
    logic       sel_rs;
    logic [2:0] sel_wait;
    logic       rs_now;
    logic [3:0] nib_now;

    // request classification
    always_comb
    begin
        stat.out_free = !out_valid_reg || out_ready;
        if (req_type == REQ_INIT)
            stat.cls = CLS_INIT;
        else if ((req_type == REQ_CHAR && char_code == CHAR_NEWLINE) ||
                 (req_type == REQ_FLAG && flag_select == FLAG_UNNAMED))
            stat.cls = CLS_SKIP;
        else
            stat.cls = CLS_BYTE;
    end

    always_comb
    begin
        case (flag_select)
            FLAG_DISPLAY: flag_bit = 8'h04;
            FLAG_CURSOR:  flag_bit = 8'h02;
            FLAG_BLINK:   flag_bit = 8'h01;
            default:      flag_bit = 8'h00;
        endcase
    end

    assign line_base = line_sel ? second_line_reg : 7'd0;
    assign pos_addr  = line_base + column;

    always_comb
    begin
        display_mode_next = display_mode_reg;
        if (req_type == REQ_FLAG)
            display_mode_next = flag_value ? (display_mode_reg | flag_bit)
                                           : (display_mode_reg & ~flag_bit);
        else if (req_type == REQ_INIT)
            display_mode_next = LCD_DISPLAY | {5'd0, display_bits_reg};

        byte_rs_next   = 1'b0;
        byte_wait_next = WAIT_3MS;
        case (req_type)
            REQ_CHAR:
            begin
                if (char_code == CHAR_FORM_FEED)
                begin
                    byte_next      = LCD_CLEAR;
                    byte_wait_next = WAIT_8MS;
                end
                else if (char_code == CHAR_RETURN)
                    byte_next = LCD_SET_ADDR | {1'b0, second_line_reg};
                else
                begin
                    byte_next    = char_code;
                    byte_rs_next = 1'b1;
                end
            end
            REQ_POS:  byte_next = LCD_SET_ADDR | {1'b0, pos_addr};
            REQ_FLAG: byte_next = display_mode_next;
            default:  byte_next = LCD_CLEAR;
        endcase
    end

    // byte currently going out
    always_comb
    begin
        sel_rs   = 1'b0;
        sel_wait = WAIT_3MS;
        unique case (cmd.byte_sel)
            BSEL_REQ:
            begin
                sel_byte = byte_reg;
                sel_rs   = byte_rs_reg;
                sel_wait = byte_wait_reg;
            end
            BSEL_FUNC:  sel_byte = LCD_FUNCTION | {3'd0, function_bits_reg};
            BSEL_DISP:  sel_byte = display_mode_reg;
            BSEL_CLEAR:
            begin
                sel_byte = LCD_CLEAR;
                sel_wait = WAIT_8MS;
            end
            default:    sel_byte = LCD_ENTRY_MODE;
        endcase
    end

    always_comb
    begin
        unique case (cmd.rs_sel)
            RS_ZERO: rs_now = 1'b0;
            RS_BYTE: rs_now = sel_rs;
            default: rs_now = held_rs_reg;
        endcase
        unique case (cmd.nib_sel)
            NIB_ZERO:  nib_now = 4'h0;
            NIB_HI:    nib_now = sel_byte[7:4];
            NIB_LO:    nib_now = sel_byte[3:0];
            NIB_THREE: nib_now = NIB_INIT_THREE;
            NIB_TWO:   nib_now = NIB_INIT_TWO;
            default:   nib_now = held_nibble_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            function_bits_reg <= 5'd8;
            display_bits_reg  <= 3'd4;
            second_line_reg   <= 7'd64;
            display_mode_reg  <= 8'd0;
            held_rs_reg       <= 1'b0;
            held_nibble_reg   <= 4'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_FUNCTION_BITS: function_bits_reg <= cfg_data[4:0];
                    CFG_DISPLAY_BITS:  display_bits_reg  <= cfg_data[2:0];
                    CFG_SECOND_LINE:   second_line_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load_req)
                display_mode_reg <= display_mode_next;
            if (cmd.emit)
            begin
                held_rs_reg     <= rs_now;
                held_nibble_reg <= nib_now;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            byte_reg      <= byte_next;
            byte_rs_reg   <= byte_rs_next;
            byte_wait_reg <= byte_wait_next;
        end
        if (cmd.emit)
        begin
            rs_reg     <= rs_now;
            en_reg     <= cmd.en;
            nibble_reg <= nib_now;
            wait_reg   <= cmd.end_wait ? sel_wait : cmd.wait_code;
            last_reg   <= cmd.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pin_rs      = rs_reg;
    assign pin_en      = en_reg;
    assign pin_nibble  = nibble_reg;
    assign wait_code   = wait_reg;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire

[hdl/char_lcd_nibble_writer_core.sv]
// top level of the character lcd 4-bit nibble writer
`default_nettype none

// Turns requests into hd44780 4-bit bus pin states, one result per pin state,
// each tagged with a hold code and last_of_run on the final one. A character,
// position or display-flag request yields eight states, an initialize request
// 45, a newline or an unnamed flag none (the request is taken and the block is
// ready again at once). The sequencer emits at most one pin state per cycle
// into a single output register, after the request transfer in idle. It
// stalls while the output register is full and not being taken; in_ready is
// high only between requests, including while the final state still waits.
// Configuration writes (function bits, display bits, line-two address) are
// always taken and should only be made between requests.
module char_lcd_nibble_writer_core
    import clnw_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [1:0]             req_type,
    input  wire logic [7:0]             char_code,
    input  wire logic [6:0]             column,
    input  wire logic                   line_sel,
    input  wire logic [1:0]             flag_select,
    input  wire logic                   flag_value,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        pin_rs,
    output logic                        pin_en,
    output logic [3:0]                  pin_nibble,
    output logic [2:0]                  wait_code,
    output logic                        last_of_run
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    clnw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    clnw_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_type    (req_type),
        .char_code   (char_code),
        .column      (column),
        .line_sel    (line_sel),
        .flag_select (flag_select),
        .flag_value  (flag_value),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pin_rs      (pin_rs),
        .pin_en      (pin_en),
        .pin_nibble  (pin_nibble),
        .wait_code   (wait_code),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

[hdl/clnw_checker.sv]
// port-level checks for the nibble writer, bound to the top level
`default_nettype none

module clnw_checker
    import clnw_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_ready,
    input wire logic [1:0]             req_type,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic                   pin_rs,
    input wire logic                   pin_en,
    input wire logic [3:0]             pin_nibble,
    input wire logic [2:0]             wait_code,
    input wire logic                   last_of_run
);

    // a stalled result transfer holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pin_rs) && $stable(pin_en)
            && $stable(pin_nibble) && $stable(wait_code) && $stable(last_of_run))
    else $error("result changed while stalled");

    // an init request keeps the block busy afterwards
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && req_type == REQ_INIT |=> !in_ready)
    else $error("ready after init transfer");

    // enable high states are always the short pulse hold
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pin_en |-> wait_code == WAIT_PULSE)
    else $error("enable high with wrong hold");

    // a run always ends with enable low
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_run |-> !pin_en)
    else $error("run ends with enable high");

    // between requests only the final state of a run can be waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> last_of_run)
    else $error("ready while a run is unfinished");

endmodule

bind char_lcd_nibble_writer_core clnw_checker u_clnw_checker (.*);

`default_nettype wire
